// File: rtl/aes_cbc_pkg.sv
package aes_cbc_pkg;

    localparam int RK_WORDS = 60;
    localparam int RK_AW    = 6;
    localparam int RND_W    = 4;

    localparam logic [2:0] REG_KEY_LEN = 3'd0;
    localparam logic [2:0] REG_KEY_W0  = 3'd1;
    localparam logic [2:0] REG_KEY_W1  = 3'd2;
    localparam logic [2:0] REG_KEY_W2  = 3'd3;
    localparam logic [2:0] REG_KEY_W3  = 3'd4;
    localparam logic [2:0] REG_IV_HI   = 3'd5;
    localparam logic [2:0] REG_IV_LO   = 3'd6;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Bytes of the state: byte 0 in bits [127:120], byte r + 4c is row r, column c.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] o;
        int src;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = r + 4 * ((c + r) % 4);
                o[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
            end
        end
        sub_shift = o;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] o;
        int src;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = r + 4 * ((c + 4 - r) % 4);
                o[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
            end
        end
        inv_sub_shift = o;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            o[127 - 32 * c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[119 - 32 * c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[111 - 32 * c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[103 - 32 * c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        mix_cols = o;
    endfunction

    // Inverse mix as a pre-step (x4 correction) followed by the forward mix.
    function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
        logic [127:0] p;
        logic [7:0] u, v;
        p = s;
        for (int c = 0; c < 4; c++) begin
            u = xt(xt(s[127 - 32 * c -: 8] ^ s[111 - 32 * c -: 8]));
            v = xt(xt(s[119 - 32 * c -: 8] ^ s[103 - 32 * c -: 8]));
            p[127 - 32 * c -: 8] = s[127 - 32 * c -: 8] ^ u;
            p[119 - 32 * c -: 8] = s[119 - 32 * c -: 8] ^ v;
            p[111 - 32 * c -: 8] = s[111 - 32 * c -: 8] ^ u;
            p[103 - 32 * c -: 8] = s[103 - 32 * c -: 8] ^ v;
        end
        inv_mix_cols = mix_cols(p);
    endfunction

    typedef struct packed {
        logic             start;
        logic [1:0]       key_len;
        logic [255:0]     key;
    } kexp_req_t;

    typedef struct packed {
        logic             busy;
        logic [RND_W-1:0] rounds;
    } kexp_stat_t;

endpackage

// File: rtl/aes_cbc_ram.sv
module aes_cbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/aes_cbc_kexp.sv
module aes_cbc_kexp
    import aes_cbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  kexp_req_t         req,
    output kexp_stat_t        stat,
    output logic              we,
    output logic [RK_AW-1:0]  waddr,
    output logic [31:0]       wdata
);

    // Keep a sliding window of the last eight words; one word per cycle.
    logic [31:0]      win_reg [8];
    logic [31:0]      win_next [8];
    logic [RK_AW-1:0] idx_reg, idx_next;
    logic [RK_AW-1:0] total_reg, total_next;
    logic [3:0]       nk_reg, nk_next;
    logic [2:0]       pos_reg, pos_next;
    logic [3:0]       rci_reg, rci_next;
    logic             busy_reg, busy_next;
    logic [RND_W-1:0] rounds_reg, rounds_next;
    logic [31:0]      t, nw, prev, back;
    logic [1:0]       kl;

    assign kl = (req.key_len == 2'd3) ? 2'd2 : req.key_len;

    always_comb
    begin
        prev = win_reg[0];
        back = win_reg[nk_reg[2:0] - 3'd1];
        t = prev;
        if (pos_reg == 3'd0)
        begin
            t = sub_word({prev[23:0], prev[31:24]}) ^ {RCON[rci_reg], 24'd0};
        end
        else if (nk_reg == 4'd8 && pos_reg == 3'd4)
        begin
            t = sub_word(prev);
        end
        nw = back ^ t;
    end

    always_comb
    begin
        win_next    = win_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        nk_next     = nk_reg;
        pos_next    = pos_reg;
        rci_next    = rci_reg;
        busy_next   = busy_reg;
        rounds_next = rounds_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = nw;
        if (req.start)
        begin
            // Load the key words; they are written out first by the walk below.
            for (int i = 0; i < 8; i++)
            begin
                win_next[i] = req.key[32 * i +: 32];
            end
            nk_next     = 4'd4 + {1'b0, kl, 1'b0};
            rounds_next = 4'd10 + {1'b0, kl, 1'b0};
            total_next  = RK_AW'(6'd44 + {2'd0, kl, 3'd0});
            idx_next    = '0;
            pos_next    = '0;
            rci_next    = 4'd1;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            we = 1'b1;
            if (idx_reg < RK_AW'(nk_reg))
            begin
                wdata = win_reg[idx_reg[2:0]];
            end
            else
            begin
                for (int i = 7; i > 0; i--)
                begin
                    win_next[i] = win_reg[i - 1];
                end
                win_next[0] = nw;
                pos_next = (pos_reg == nk_reg[2:0] - 3'd1) ? 3'd0 : pos_reg + 3'd1;
                if (pos_reg == 3'd0)
                begin
                    rci_next = rci_reg + 4'd1;
                end
            end
            if (idx_reg == RK_AW'(nk_reg) - RK_AW'(1))
            begin
                // Reverse the key so that word nk-1 sits at slot 0.
                for (int i = 0; i < 8; i++)
                begin
                    win_next[i] = (i < 8) ? win_reg[(nk_reg[2:0] - 3'd1 - 3'(i)) & 3'd7] : 32'd0;
                end
                if (nk_reg == 4'd8)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        win_next[i] = win_reg[7 - i];
                    end
                end
                pos_next = 3'd0;
            end
            idx_next = idx_reg + RK_AW'(1);
            if (idx_reg == total_reg - RK_AW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            rounds_reg <= 4'd10;
            idx_reg    <= '0;
            total_reg  <= '0;
            nk_reg     <= 4'd4;
            pos_reg    <= '0;
            rci_reg    <= 4'd1;
        end
        else
        begin
            busy_reg   <= busy_next;
            rounds_reg <= rounds_next;
            idx_reg    <= idx_next;
            total_reg  <= total_next;
            nk_reg     <= nk_next;
            pos_reg    <= pos_next;
            rci_reg    <= rci_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.rounds = rounds_reg;

endmodule

// File: rtl/aes_cbc_core.sv
module aes_cbc_core
    import aes_cbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic              restart,
    input  logic [127:0]      blk,
    input  logic [127:0]      iv,
    input  logic [RND_W-1:0]  rounds,
    output logic [RK_AW-1:0]  raddr,
    input  logic [31:0]       rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [127:0]      res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_ROUND = 5'b00100,
        S_LAST  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [127:0]     st_reg, st_next;
    logic [127:0]     chain_reg, chain_next;
    logic [127:0]     save_reg, save_next;
    logic [127:0]     rk_reg, rk_next;
    logic             dec_reg, dec_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [1:0]       col_reg, col_next;
    logic [127:0]     rk_full, body, res_reg, res_next;

    // Round key word address: round * 4 + column, issued in the cycle before its use
    assign raddr = RK_AW'({rnd_next, 2'b00}) + RK_AW'(col_next);

    always_comb
    begin
        rk_full = rk_reg;
        rk_full[127 - 32 * col_reg -: 32] = rdata;
        if (dec_reg)
        begin
            body = (rnd_reg == '0) ? inv_sub_shift(st_reg) :
                   inv_mix_cols(inv_sub_shift(st_reg) ^ rk_full);
        end
        else
        begin
            body = (rnd_reg == rounds) ? sub_shift(st_reg) : mix_cols(sub_shift(st_reg));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        chain_next = chain_reg;
        save_next  = save_reg;
        rk_next    = rk_reg;
        dec_next   = dec_reg;
        rnd_next   = rnd_reg;
        col_next   = col_reg;
        res_next   = res_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                col_next = '0;
                if (in_valid)
                begin
                    dec_next  = func;
                    save_next = blk;
                    if (restart)
                    begin
                        chain_next = iv;
                    end
                    st_next  = func ? blk : (blk ^ (restart ? iv : chain_reg));
                    rnd_next = func ? rounds : '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // Gather four key words; word k arrives in the cycle after its address.
                rk_next = rk_full;
                col_next = col_reg + 2'd1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                rk_next = rk_full;
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd3)
                begin
                    col_next = '0;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // rk_reg holds the full key of round rnd_reg
                if (dec_reg)
                begin
                    if (rnd_reg == rounds)
                    begin
                        st_next = st_reg ^ rk_reg;
                    end
                    else if (rnd_reg == '0)
                    begin
                        st_next = inv_sub_shift(st_reg) ^ rk_reg;
                    end
                    else
                    begin
                        st_next = inv_mix_cols(inv_sub_shift(st_reg) ^ rk_reg);
                    end
                end
                else
                begin
                    st_next = (rnd_reg == '0) ? (st_reg ^ rk_reg) : (body ^ rk_reg);
                end
                if ((dec_reg && rnd_reg == '0) || (!dec_reg && rnd_reg == rounds))
                begin
                    state_next = S_OUT;
                    col_next   = '0;
                end
                else
                begin
                    rnd_next   = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    col_next   = '0;
                    state_next = S_FETCH;
                end
            end
            S_OUT:
            begin
                if (dec_reg)
                begin
                    res_next   = st_reg ^ chain_reg;
                    chain_next = save_reg;
                end
                else
                begin
                    res_next   = st_reg;
                    chain_next = st_reg;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output holding register; the core holds its final step only while it is full.
    logic rv_reg, rv_next;
    logic out_busy;
    assign out_busy = rv_reg && !res_ready;

    always_comb
    begin
        rv_next = rv_reg;
        if (res_ready)
        begin
            rv_next = 1'b0;
        end
        if (state_reg == S_OUT)
        begin
            rv_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chain_reg <= '0;
            rv_reg    <= 1'b0;
            rnd_reg   <= '0;
            col_reg   <= '0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            // Hold in S_OUT while the previous result has not been taken.
            if (state_reg == S_OUT && out_busy)
            begin
                state_reg <= state_reg;
            end
            else
            begin
                state_reg <= state_next;
                chain_reg <= chain_next;
                rnd_reg   <= rnd_next;
                col_reg   <= col_next;
                dec_reg   <= dec_next;
            end
            rv_reg <= (state_reg == S_OUT && out_busy) ? rv_reg : rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!(state_reg == S_OUT && out_busy))
        begin
            st_reg   <= st_next;
            save_reg <= save_next;
            rk_reg   <= rk_next;
            res_reg  <= res_next;
        end
    end

    assign res_valid = rv_reg;
    assign res       = res_reg;

endmodule

// File: rtl/aes_cbc_block_cipher.sv
// AES-128/192/256 in CBC mode, one 128-bit block per request.
// Channels: s_axis_* takes {block_low, block_high} in tdata and {restart, func} in
// tuser; m_axis_* returns {result_low, result_high}. cfg_* writes one of seven
// registers: key length, four key words, IV high, IV low.
// Writing the key length or a key word re-expands the round keys into a 60 x 32
// RAM, one word per cycle; requests wait meanwhile. After reset the all-zero
// 128-bit key is expanded, and s_axis_tready stays low until that is done.
// Round sequence: each round fetches its four key words from the RAM, one per
// state (S_FETCH, then S_ROUND for the other three), and applies the round in
// S_LAST; after the last round S_OUT registers the result. The single read port
// of the key RAM is why the words come one at a time. One block is in flight at
// a time, since each block chains on the previous result.
// The result sits in an output register; the next request is accepted while it
// waits, and the core holds its final step while the receiver stalls.
// Reset clears the chain to zero; restart=1 reloads it from the IV.
module aes_cbc_block_cipher
    import aes_cbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
    input  logic [1:0]   s_axis_tuser,   // func [0], restart [1]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // result_high [63:0], result_low [127:64]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic [1:0]       klen_reg;
    logic [63:0]      kw_reg [4];
    logic [63:0]      ivh_reg, ivl_reg;
    logic             boot_reg;
    logic             cfg_we;
    kexp_req_t        kreq;
    kexp_stat_t       kstat;
    logic             rk_we;
    logic [RK_AW-1:0] rk_waddr, rk_raddr;
    logic [31:0]      rk_wdata, rk_rdata;
    logic             core_valid, core_ready;
    logic [127:0]     res;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg <= '0;
            kw_reg   <= '{default: '0};
            ivh_reg  <= '0;
            ivl_reg  <= '0;
            boot_reg <= 1'b1;
        end
        else
        begin
            boot_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_LEN: klen_reg  <= cfg_data[1:0];
                    REG_KEY_W0:  kw_reg[0] <= cfg_data;
                    REG_KEY_W1:  kw_reg[1] <= cfg_data;
                    REG_KEY_W2:  kw_reg[2] <= cfg_data;
                    REG_KEY_W3:  kw_reg[3] <= cfg_data;
                    REG_IV_HI:   ivh_reg   <= cfg_data;
                    REG_IV_LO:   ivl_reg   <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // Restart expansion in the cycle after any key write, once the register holds it.
    logic kdirty_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kdirty_reg <= 1'b0;
        end
        else
        begin
            kdirty_reg <= cfg_we && (cfg_index == REG_KEY_LEN || cfg_index == REG_KEY_W0 ||
                          cfg_index == REG_KEY_W1 || cfg_index == REG_KEY_W2 ||
                          cfg_index == REG_KEY_W3);
        end
    end

    assign kreq.start   = boot_reg || kdirty_reg;
    assign kreq.key_len = klen_reg;
    // Word i of the key (i = 0 most significant of key word 0) at bits [32i +: 32]
    assign kreq.key = {kw_reg[3][31:0], kw_reg[3][63:32], kw_reg[2][31:0], kw_reg[2][63:32],
                       kw_reg[1][31:0], kw_reg[1][63:32], kw_reg[0][31:0], kw_reg[0][63:32]};

    aes_cbc_kexp u_kexp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (kreq),
        .stat  (kstat),
        .we    (rk_we),
        .waddr (rk_waddr),
        .wdata (rk_wdata)
    );

    aes_cbc_ram #(
        .WIDTH (32),
        .DEPTH (RK_WORDS)
    ) u_rk_ram (
        .clk   (clk),
        .we    (rk_we),
        .waddr (rk_waddr),
        .wdata (rk_wdata),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    // Hold requests off while keys are being expanded.
    assign core_valid    = s_axis_tvalid && !kstat.busy && !kreq.start;
    assign s_axis_tready = core_ready && !kstat.busy && !kreq.start;

    aes_cbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_valid),
        .in_ready  (core_ready),
        .func      (s_axis_tuser[0]),
        .restart   (s_axis_tuser[1]),
        .blk       ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .iv        ({ivh_reg, ivl_reg}),
        .rounds    (kstat.rounds),
        .raddr     (rk_raddr),
        .rdata     (rk_rdata),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {res[63:0], res[127:64]};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        kstat.busy |-> !s_axis_tready)
        else $error("request taken during key expansion");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        kstat.rounds == 4'd10 || kstat.rounds == 4'd12 || kstat.rounds == 4'd14)
        else $error("bad round count");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import aes_cbc_pkg::*;

    typedef enum bit {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} cipher_op_e;

    // Index past the last register: the block must drop such writes.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        bit [63:0] result_high;
        bit [63:0] result_low;
    } cipher_block_t;

    // Holds the expected cipher results in order and checks each returned block.
    class cbc_scoreboard;
        cipher_block_t pending_q[$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_request(bit [63:0] exp_high, bit [63:0] exp_low);
            cipher_block_t b;
            b.result_high = exp_high;
            b.result_low  = exp_low;
            pending_q.push_back(b);
        endfunction

        function void check_result(bit [63:0] got_high, bit [63:0] got_low);
            cipher_block_t b;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: result_high %h result_low %h", got_high, got_low);
                mismatches++;
                return;
            end
            b = pending_q.pop_front();
            if (b.result_high !== got_high)
            begin
                $error("result_high: expected %h, actual %h", b.result_high, got_high);
                mismatches++;
            end
            if (b.result_low !== got_low)
            begin
                $error("result_low: expected %h, actual %h", b.result_low, got_low);
                mismatches++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    // Pacing control: clear these for a stretch with no idling on either side.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    cbc_scoreboard sb = new();

    aes_cbc_block_cipher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Cipher predictor: own copy of the registers, round keys and chain.
    // ------------------------------------------------------------------
    bit [7:0]  fwd_box [256];
    bit [7:0]  inv_box [256];
    bit [1:0]  key_len_q;
    bit [63:0] key_words_q [4];
    bit [63:0] iv_high_q, iv_low_q;
    bit [63:0] chain_high_q, chain_low_q;
    bit [31:0] rkeys [60];
    int        nrounds;

    function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] m);
        bit [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (m[i])
                acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Build both substitution boxes from the field inverse and the affine map.
    function automatic void build_boxes();
        bit [7:0] inv, b, y;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int c = 1; c < 256; c++)
                if (x != 0 && gf_mul(x[7:0], c[7:0]) == 8'h01)
                    inv = c[7:0];
            b = inv;
            y = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
                ^ 8'h63;
            fwd_box[x] = y;
            inv_box[y] = x[7:0];
        end
    endfunction

    function automatic bit [31:0] box_word(bit [31:0] w);
        return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
    endfunction

    function automatic void expand_round_keys();
        int        nk, total;
        bit [31:0] t;
        bit [7:0]  rc;
        nk = (key_len_q == 2'd0) ? 4 : (key_len_q == 2'd1) ? 6 : 8;
        nrounds = nk + 6;
        total = 4 * (nrounds + 1);
        for (int i = 0; i < 60; i++)
            rkeys[i] = '0;
        for (int i = 0; i < nk; i++)
            rkeys[i] = i[0] ? key_words_q[i / 2][31:0] : key_words_q[i / 2][63:32];
        rc = 8'h01;
        for (int i = nk; i < total; i++)
        begin
            t = rkeys[i - 1];
            if (i % nk == 0)
            begin
                t = box_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            else if (nk > 6 && i % nk == 4)
                t = box_word(t);
            rkeys[i] = rkeys[i - nk] ^ t;
        end
    endfunction

    function automatic void apply_reg(bit [2:0] idx, bit [63:0] val);
        case (idx)
            REG_KEY_LEN: key_len_q = (val[1:0] == 2'd3) ? 2'd2 : val[1:0];
            REG_KEY_W0, REG_KEY_W1, REG_KEY_W2, REG_KEY_W3: key_words_q[idx - 1] = val;
            REG_IV_HI: iv_high_q = val;
            REG_IV_LO: iv_low_q = val;
            default: ;
        endcase
        if (idx <= REG_KEY_W3)
            expand_round_keys();
    endfunction

    // One AES pass on a 128-bit state, byte 0 in the top bits.
    function automatic bit [127:0] aes_pass(bit [127:0] blk, bit inverse);
        bit [7:0] s [16];
        bit [7:0] t [16];
        bit [7:0] col [4];
        bit [7:0] fm [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
        bit [7:0] im [4] = '{8'd14, 8'd11, 8'd13, 8'd9};
        bit [127:0] res;
        int rnd, src;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8 * i -: 8];
        for (int step = 0; step <= nrounds; step++)
        begin
            rnd = inverse ? nrounds - step : step;
            if (step > 0)
            begin
                // Substitute and shift rows (order does not matter, both are bytewise).
                t = s;
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                    begin
                        src = inverse ? (c + 4 - r) % 4 : (c + r) % 4;
                        s[r + 4 * c] = inverse ? inv_box[t[r + 4 * src]]
                                               : fwd_box[t[r + 4 * src]];
                    end
                if (!inverse && step < nrounds)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int r = 0; r < 4; r++)
                            col[r] = s[4 * c + r];
                        for (int r = 0; r < 4; r++)
                            s[4 * c + r] = gf_mul(col[0], fm[(4 - r) % 4])
                                ^ gf_mul(col[1], fm[(5 - r) % 4])
                                ^ gf_mul(col[2], fm[(6 - r) % 4])
                                ^ gf_mul(col[3], fm[(7 - r) % 4]);
                    end
            end
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++)
                    s[4 * c + b] ^= rkeys[4 * rnd + c][31 - 8 * b -: 8];
            // Decrypt applies the inverse mix after the round key.
            if (inverse && step > 0 && step < nrounds)
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++)
                        col[r] = s[4 * c + r];
                    for (int r = 0; r < 4; r++)
                        s[4 * c + r] = gf_mul(col[0], im[(4 - r) % 4])
                            ^ gf_mul(col[1], im[(5 - r) % 4])
                            ^ gf_mul(col[2], im[(6 - r) % 4])
                            ^ gf_mul(col[3], im[(7 - r) % 4]);
                end
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    // Advance the chain for one accepted request and return its expected block.
    function automatic bit [127:0] cbc_predict(cipher_op_e op, bit restart, bit [127:0] blk);
        bit [127:0] res;
        if (restart)
        begin
            chain_high_q = iv_high_q;
            chain_low_q  = iv_low_q;
        end
        if (op == OP_ENCRYPT)
        begin
            res = aes_pass(blk ^ {chain_high_q, chain_low_q}, 1'b0);
            {chain_high_q, chain_low_q} = res;
        end
        else
        begin
            res = aes_pass(blk, 1'b1) ^ {chain_high_q, chain_low_q};
            {chain_high_q, chain_low_q} = blk;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic cfg_write(bit [2:0] idx, bit [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    // Keep tvalid high across back-to-back requests; drop it only to idle.
    task automatic send_block(cipher_op_e op, bit restart, bit [63:0] hi, bit [63:0] lo);
        bit [127:0] res;
        if (tx_idle_on && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        s_axis_tuser  <= {restart, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = cbc_predict(op, restart, {hi, lo});
        sb.note_request(res[127:64], res[63:0]);
    endtask

    // Hold off config writes until every expected block is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Receiver: stall at random, except during the steady stretch.
    always @(posedge clk)
        m_axis_tready <= !rx_idle_on || ($urandom_range(99) >= 11);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64]);

    initial
    begin
        #30000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int  msg_len;
        bit  op;
        key_len_q = '0;
        for (int i = 0; i < 4; i++)
            key_words_q[i] = '0;
        iv_high_q = '0;
        iv_low_q = '0;
        chain_high_q = '0;
        chain_low_q = '0;
        build_boxes();
        expand_round_keys();

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero key and zero chain straight out of reset, no restart.
        send_block(OP_ENCRYPT, 1'b0, '0, '0);
        send_block(OP_DECRYPT, 1'b0, '1, '1);
        drain();

        // Standard 128-bit key; IV write takes effect only at the restart.
        cfg_write(REG_KEY_W0, 64'h2b7e151628aed2a6);
        cfg_write(REG_KEY_W1, 64'habf7158809cf4f3c);
        cfg_write(REG_KEY_W2, 64'hffffffffffffffff);
        cfg_write(REG_IV_HI, 64'h0001020304050607);
        cfg_write(REG_IV_LO, 64'h08090a0b0c0d0e0f);
        cfg_write(REG_UNUSED, 64'hdeadbeefdeadbeef);
        send_block(OP_ENCRYPT, 1'b0, 64'h6bc1bee22e409f96, 64'he93d7e117393172a);
        send_block(OP_ENCRYPT, 1'b1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a);
        send_block(OP_ENCRYPT, 1'b0, '1, '0);
        send_block(OP_DECRYPT, 1'b0, '0, '1);
        send_block(OP_DECRYPT, 1'b1, 64'h7649abac8119b246, 64'hcee98e9b12e9197d);
        drain();

        // 192-bit, 256-bit and the unused length code, with the upper key words all ones.
        for (int kl = 1; kl < 4; kl++)
        begin
            cfg_write(REG_KEY_LEN, 64'(kl));
            cfg_write(REG_KEY_W2, '1);
            cfg_write(REG_KEY_W3, (kl == 1) ? 64'h0 : '1);
            send_block(OP_ENCRYPT, 1'b1, '0, '1);
            send_block(OP_DECRYPT, 1'b0, '1, '0);
            send_block(OP_ENCRYPT, 1'b0, '1, '1);
            drain();
        end

        // Random phases: new key length, key and IV registers rewritten at random, then CBC messages of random length.
        for (int ph = 0; ph < 12; ph++)
        begin
            tx_idle_on = (ph != 3);
            rx_idle_on = (ph != 3);
            cfg_write(REG_KEY_LEN, 64'((ph < 3) ? ph : $urandom_range(3)));
            for (int r = 1; r < 8; r++)
                if (r == REG_UNUSED || $urandom_range(3) != 0)
                    cfg_write(r[2:0], (ph == 4) ? 64'h0 : (ph == 5) ? '1 : rand64());
            for (int n = 0; n < 100; n += msg_len)
            begin
                msg_len = $urandom_range(8, 1);
                op = 1'($urandom_range(1));
                for (int k = 0; k < msg_len; k++)
                begin
                    // Mostly well-formed messages; now and then flip direction mid-chain.
                    if ($urandom_range(9) == 0)
                        op = ~op;
                    send_block(cipher_op_e'(op), (k == 0) && ($urandom_range(7) != 0),
                               rand64(), rand64());
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
